// ----- rtl/bpsma_pkg.sv -----
package bpsma_pkg;

    // Canvas geometry and number formats.
    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 256;
    localparam int FRAC_BITS     = 8;
    localparam int COLOR_BITS    = 24;

    localparam int PIXEL_COUNT = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int PIX_W       = COLOR_BITS + 8;

    // Integer part of a 16-bit coordinate, one bit wider so that the
    // right-hand and lower neighbors never wrap.
    localparam int IX_W = 17 - FRAC_BITS;

    // Weight arithmetic: one-minus-fraction needs one more bit, the weight
    // product reaches exactly 2^(2*FRAC_BITS), and the alpha sum adds 8 bits.
    localparam int FX_W  = FRAC_BITS + 1;
    localparam int W_W   = 2 * FRAC_BITS + 1;
    localparam int SUM_W = W_W + 8;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    typedef logic [3:0][7:0] t_alpha4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WEIGHT,
        ST_ALPHA,
        ST_ACCESS,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/bpsma_alpha.sv -----
module bpsma_alpha (
    input  logic                           i_clk,
    input  logic [bpsma_pkg::FRAC_BITS-1:0] i_fx,
    input  logic [bpsma_pkg::FRAC_BITS-1:0] i_fy,
    output bpsma_pkg::t_alpha4             o_alpha
);
    import bpsma_pkg::*;

    localparam logic [FX_W-1:0]  ONE_FX = FX_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (2 * FRAC_BITS - 1);

    logic [FX_W-1:0] fx;
    logic [FX_W-1:0] fy;
    logic [FX_W-1:0] gx;
    logic [FX_W-1:0] gy;

    logic [W_W-1:0] r_w [4];
    t_alpha4        n_alpha;
    t_alpha4        r_alpha;

    assign fx = FX_W'(i_fx);
    assign fy = FX_W'(i_fy);
    assign gx = ONE_FX - fx;
    assign gy = ONE_FX - fy;

    // First stage: the four bilinear weights, scaled by 2^(2*FRAC_BITS).
    always_ff @(posedge i_clk) begin
        r_w[0] <= W_W'(W_W'(gx) * W_W'(gy));
        r_w[1] <= W_W'(W_W'(fx) * W_W'(gy));
        r_w[2] <= W_W'(W_W'(gx) * W_W'(fy));
        r_w[3] <= W_W'(W_W'(fx) * W_W'(fy));
    end

    // Second stage: alpha = round(w * 255) with ties rounded up, clamped.
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [8:0]       a9;
        n_alpha = '0;
        for (int k = 0; k < 4; k++) begin
            sum = (SUM_W'(r_w[k]) << 8) - SUM_W'(r_w[k]) + HALF;
            a9  = sum[SUM_W-1 -: 9];
            n_alpha[k] = a9[8] ? 8'hFF : a9[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= n_alpha;
    end

    assign o_alpha = r_alpha;

endmodule

// ----- rtl/bilinear_point_splat_max_alpha.sv -----
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tuser: mode; tdata: x_pos, y_pos, point_color
// m_axis    out        tdata: read_color, read_alpha, written_mask
//
// After an input transfer the weight and alpha states compute the alphas,
// then the access state does one canvas read a cycle (four neighbors for a
// plot, one for a read), each overlapped with the compare and write-back of
// the previous neighbor; the canvas's single read port serializes them.
// After reset a clearing pass writes zero to all 65536 pixels, one per cycle,
// and no input is taken until it ends. A finished item waits in its last state
// until the output register is free, and no input is taken meanwhile.
module bilinear_point_splat_max_alpha (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_pos[15:0], y_pos[31:16], point_color[55:32]
    input  logic [bpsma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // read_color[23:0], read_alpha[31:24], written_mask[35:32], zero fill
    output logic [bpsma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bpsma_pkg::*;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PIXEL_COUNT - 1);

    t_state r_state;
    t_state n_state;

    // Item fields.
    logic                  r_mode;
    logic [IX_W-1:0]       r_ix;
    logic [IX_W-1:0]       r_iy;
    logic [FRAC_BITS-1:0]  r_fx;
    logic [FRAC_BITS-1:0]  r_fy;
    logic [COLOR_BITS-1:0] r_color;
    logic [1:0]            r_k;

    t_alpha4 alpha;

    // Neighbor address generation.
    logic [IX_W-1:0]   col;
    logic [IX_W-1:0]   row;
    logic              in_canvas;
    logic [ADDR_W-1:0] nb_addr;

    // Compare stage, in the cycle after the read.
    logic              r_chk_valid;
    logic [1:0]        r_chk_k;
    logic              r_chk_in;
    logic [ADDR_W-1:0] r_chk_addr;
    logic [7:0]        rd_alpha;
    logic              hit;

    // Canvas memory.
    logic [PIX_W-1:0]  canvas [PIXEL_COUNT];
    logic [PIX_W-1:0]  r_rd_data;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic [ADDR_W-1:0] r_clr_addr;

    // Result.
    logic [3:0]  r_mask;
    logic [23:0] r_res_color;
    logic [7:0]  r_res_alpha;
    logic        r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic        out_free;
    logic        accept;

    logic [63:0] in_color64;
    logic [63:0] rd_color64;

    bpsma_alpha u_alpha (
        .i_clk   (i_clk),
        .i_fx    (r_fx),
        .i_fy    (r_fy),
        .o_alpha (alpha)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = ST_WEIGHT;
            end
            ST_WEIGHT: n_state = ST_ALPHA;
            ST_ALPHA:  n_state = ST_ACCESS;
            ST_ACCESS: begin
                if (r_mode || r_k == 2'd3) n_state = ST_FINISH;
            end
            ST_FINISH: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Neighbor r_k: bit 0 steps one column right, bit 1 one row down.
    assign col       = r_ix + IX_W'(r_k[0]);
    assign row       = r_iy + IX_W'(r_k[1]);
    assign in_canvas = (32'(col) < 32'(CANVAS_WIDTH)) && (32'(row) < 32'(CANVAS_HEIGHT));
    assign nb_addr   = ADDR_W'(32'(row) * 32'(CANVAS_WIDTH) + 32'(col));

    assign rd_en    = (r_state == ST_ACCESS) && in_canvas;
    assign rd_alpha = r_rd_data[PIX_W-1 -: 8];
    assign hit      = r_chk_valid && !r_mode && r_chk_in && (rd_alpha < alpha[r_chk_k]);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = hit;
            wr_addr = r_chk_addr;
            wr_data = {alpha[r_chk_k], r_color};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) canvas[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= canvas[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign in_color64 = 64'(s_axis_tdata[55:32]);
    assign rd_color64 = 64'(r_rd_data[COLOR_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode      <= s_axis_tuser;
            r_ix        <= IX_W'(s_axis_tdata[15:0] >> FRAC_BITS);
            r_iy        <= IX_W'(s_axis_tdata[31:16] >> FRAC_BITS);
            r_fx        <= s_axis_tdata[FRAC_BITS-1:0];
            r_fy        <= s_axis_tdata[16 +: FRAC_BITS];
            r_color     <= in_color64[COLOR_BITS-1:0];
            r_k         <= 2'd0;
            r_mask      <= 4'd0;
            r_res_color <= '0;
            r_res_alpha <= '0;
        end else begin
            if (r_state == ST_ACCESS) r_k <= r_k + 2'd1;
            if (hit) r_mask[r_chk_k] <= 1'b1;
            if (r_chk_valid && r_mode && r_chk_in) begin
                r_res_color <= rd_color64[23:0];
                r_res_alpha <= rd_alpha;
            end
        end
        r_chk_k    <= r_k;
        r_chk_in   <= in_canvas;
        r_chk_addr <= nb_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else begin
            r_chk_valid <= (r_state == ST_ACCESS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= {4'd0, r_mask, r_res_alpha, r_res_color};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/bpsma_checker.sv -----
module bpsma_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bpsma_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bpsma_pkg::*;

    // Reset empties the output register and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("output valid or input ready right after reset");

    // One item at a time: no second transfer in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready directly after a transfer");

    // A plot result carries no pixel read-back.
    a_plot_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[35:32] != 4'd0) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("written mask set together with read fields");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind bilinear_point_splat_max_alpha bpsma_checker u_bpsma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_bilinear_point_splat_max_alpha.sv -----
module tb_bilinear_point_splat_max_alpha;
    timeunit 1ns;
    timeprecision 1ps;

    import bpsma_pkg::*;

    localparam bit MODE_PLOT = 1'b0;
    localparam bit MODE_READ = 1'b1;

    localparam int ONE_FX       = 1 << FRAC_BITS;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 4;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 700000;

    typedef struct packed {
        logic [23:0] color;
        logic [7:0]  alpha;
        logic [3:0]  mask;
    } t_splat_result;

    class splat_scoreboard;
        logic [23:0]   pix_color [PIXEL_COUNT];
        logic [7:0]    pix_alpha [PIXEL_COUNT];
        t_splat_result expected_q [$];
        int            errors;

        function new();
            foreach (pix_color[i]) begin
                pix_color[i] = '0;
                pix_alpha[i] = '0;
            end
            errors = 0;
        endfunction

        // Rounds weight*255 to the nearest integer, ties up.
        function logic [7:0] weight_alpha(longint unsigned w);
            longint unsigned a;
            a = (w * 255 + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
            if (a > 255) a = 255;
            return a[7:0];
        endfunction

        function bit try_splat(int unsigned col, int unsigned row, logic [23:0] color,
                               logic [7:0] alpha);
            int unsigned idx;
            if (col >= CANVAS_WIDTH || row >= CANVAS_HEIGHT) return 1'b0;
            idx = row * CANVAS_WIDTH + col;
            if (pix_alpha[idx] < alpha) begin
                pix_color[idx] = color;
                pix_alpha[idx] = alpha;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(bit rd_mode, logic [15:0] x, logic [15:0] y,
                                 logic [23:0] c);
            int unsigned ix, iy, fx, fy, gx, gy, idx;
            logic [23:0] color;
            t_splat_result r;
            ix = 32'(x >> FRAC_BITS);
            iy = 32'(y >> FRAC_BITS);
            fx = 32'(x) & (ONE_FX - 1);
            fy = 32'(y) & (ONE_FX - 1);
            gx = ONE_FX - fx;
            gy = ONE_FX - fy;
            color = c & 24'((64'd1 << COLOR_BITS) - 1);
            r = '0;
            if (rd_mode == MODE_READ) begin
                if (ix < CANVAS_WIDTH && iy < CANVAS_HEIGHT) begin
                    idx = iy * CANVAS_WIDTH + ix;
                    r.color = pix_color[idx];
                    r.alpha = pix_alpha[idx];
                end
            end else begin
                r.mask[0] = try_splat(ix,     iy,     color, weight_alpha(gx * gy));
                r.mask[1] = try_splat(ix + 1, iy,     color, weight_alpha(fx * gy));
                r.mask[2] = try_splat(ix,     iy + 1, color, weight_alpha(gx * fy));
                r.mask[3] = try_splat(ix + 1, iy + 1, color, weight_alpha(fx * fy));
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_splat_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (d[23:0] !== exp_r.color) begin
                $display("%0t: read_color expected %h actual %h", $time, exp_r.color, d[23:0]);
                errors++;
            end
            if (d[31:24] !== exp_r.alpha) begin
                $display("%0t: read_alpha expected %h actual %h", $time, exp_r.alpha, d[31:24]);
                errors++;
            end
            if (d[35:32] !== exp_r.mask) begin
                $display("%0t: written_mask expected %h actual %h", $time, exp_r.mask,
                         d[35:32]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    splat_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              stall_left = 0;
    int unsigned     cycle_count = 0;

    bilinear_point_splat_max_alpha DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Most idle stretches are short, a few are long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check every transfer, then decide on back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(bit rd_mode, logic [15:0] x, logic [15:0] y, logic [23:0] c);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rd_mode;
        s_axis_tdata  <= {c, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(rd_mode, x, y, c);
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 45) gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_frac();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        if (r == 2) return 8'h80;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [23:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h000000;
        if (r == 1) return 24'hFFFFFF;
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    task automatic run_random(int count);
        int unsigned base_x, base_y;
        logic [15:0] x, y;
        bit          rd_mode;
        for (int n = 0; n < count; n++) begin
            // A small hot region keeps plots overlapping so the max-alpha rule and
            // reads of written pixels are exercised; it moves now and then.
            if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin base_x = 0;   base_y = 0;   end
                    1: begin base_x = 252; base_y = 252; end
                    2: begin base_x = 252; base_y = $urandom_range(0, 250); end
                    default: begin
                        base_x = $urandom_range(0, 252);
                        base_y = $urandom_range(0, 252);
                    end
                endcase
            end
            rd_mode = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_PLOT;
            if ($urandom_range(0, 99) < 75) begin
                x = {8'(base_x + $urandom_range(0, 3)), pick_frac()};
                y = {8'(base_y + $urandom_range(0, 3)), pick_frac()};
            end else begin
                x = 16'($urandom_range(0, 16'hFFFF));
                y = 16'($urandom_range(0, 16'hFFFF));
            end
            send_item(rd_mode, x, y, pick_color());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b0;
        // Fresh canvas reads as transparent black.
        send_item(MODE_READ, 16'h0000, 16'h0000, 24'hFFFFFF);
        // Integer position: full weight on the top-left pixel only.
        send_item(MODE_PLOT, 16'h0000, 16'h0000, 24'hFFFFFF);
        send_item(MODE_READ, 16'h0000, 16'h0000, 24'h000000);
        // Equal alpha does not overwrite.
        send_item(MODE_PLOT, 16'h0000, 16'h0000, 24'h000000);
        // Half step in x: tr gets alpha 128, zero-weight rows write nothing.
        send_item(MODE_PLOT, 16'h0080, 16'h0000, 24'h123456);
        // Largest fraction: tiny weights round to zero or one.
        send_item(MODE_PLOT, 16'h00FF, 16'h00FF, 24'hABCDEF);
        send_item(MODE_READ, 16'h01FF, 16'h0000, 24'h000000);
        send_item(MODE_READ, 16'h0000, 16'h01FF, 24'h000000);
        send_item(MODE_READ, 16'h01C0, 16'h0140, 24'h000000);
        idle_on = 1'b1;
        // Right and bottom neighbors fall off the canvas.
        send_item(MODE_PLOT, 16'hFFFF, 16'hFFFF, 24'h00FF00);
        send_item(MODE_PLOT, 16'hFF00, 16'hFF00, 24'hFF0000);
        send_item(MODE_PLOT, 16'hFF80, 16'h1040, 24'h0000FF);
        send_item(MODE_PLOT, 16'h2080, 16'hFF80, 24'h5A5A5A);
        send_item(MODE_READ, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_item(MODE_READ, 16'hFF00, 16'h1000, 24'h000000);
        send_item(MODE_READ, 16'h2100, 16'hFF00, 24'h000000);
        // Quarter weights on all four pixels.
        send_item(MODE_PLOT, 16'h8080, 16'h8080, 24'hA5A5A5);
        send_item(MODE_READ, 16'h8100, 16'h8100, 24'h000000);

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p != 0);
            run_random(RANDOM_ITEMS / PHASES);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
